// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker module of the event decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define CSED_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define CSED_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// File: hw/rtl/csed_pkg.sv
// Shared types and constants of the control surface event decoder.
`default_nettype none
package csed_pkg;

	// Field widths of the stream items.
	localparam int CC_W     = 7;
	localparam int TARGET_W = 4;
	localparam int STEP_W   = 14;
	localparam int ROW_W    = 3;
	localparam int COL_W    = 4;
	localparam int SLOT_W   = 5;
	localparam int CFG_IDX_W = 3;

	// Divider operand: magnitude of remainder plus accelerated delta.
	localparam int NUM_W = 14;

	// Saturation limits of step_amount.
	localparam logic [NUM_W-1:0] STEP_POS_MAX = 14'd8191;
	localparam logic [NUM_W-1:0] STEP_NEG_MAX = 14'd8192;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_DIAL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KNOB_BASE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_DIV    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL       = 3'd4;

	// Configuration reset values.
	localparam logic [CC_W-1:0] RST_BUTTON_BASE = 7'd112;
	localparam logic [CC_W-1:0] RST_SPEED_DIAL  = 7'd74;
	localparam logic [CC_W-1:0] RST_KNOB_BASE   = 7'd64;
	localparam logic [CC_W-1:0] RST_STEP_DIV    = 7'd2;
	localparam logic [CC_W-1:0] RST_ACCEL       = 7'd10;

	typedef enum logic [1:0] {
		KIND_KNOB = 2'd0,
		KIND_INC  = 2'd1,
		KIND_DEC  = 2'd2,
		KIND_JUMP = 2'd3
	} kind_t;

	typedef struct packed {
		logic [CC_W-1:0] button_base_cc;
		logic [CC_W-1:0] speed_dial_cc;
		logic [CC_W-1:0] knob_base_cc;
		logic [CC_W-1:0] step_divisor;
		logic [CC_W-1:0] acceleration;
	} cfg_t;

	// Classified event handed from the front to the back.
	typedef struct packed {
		logic                is_knob;
		kind_t               kind;
		logic [TARGET_W-1:0] target;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic [SLOT_W-1:0]   slot;
		logic [STEP_W-1:0]   delta;
	} cmd_t;

	// Finished result item.
	typedef struct packed {
		kind_t               kind;
		logic [TARGET_W-1:0] target;
		logic [STEP_W-1:0]   step;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/control_surface_event_decoder.sv
// Top level of the control surface event decoder.
`default_nettype none
// Decodes controller-change events from a control surface into knob steps,
// increment/decrement button results and chord jumps. The input stream takes
// one event per cycle while the four-entry command queue has room; button
// and speed-dial/knob classification and the button masks are settled in
// that cycle. The back end executes one queued command at a time: a button
// result is registered straight from the pop, while a knob event passes through
// pop, sum, the bit-serial divider by the knob scale and finish; the result
// register must drain before the next pop. Events that produce no result never
// enter the queue. Configuration writes are taken at any time (cfg_ready is
// always high) but must only be issued while the block is idle.
module control_surface_event_decoder #(
	parameter int BUTTON_COUNT   = 16,
	parameter int RELATIVE_KNOBS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input events
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // cc_number[6:0], cc_value[13:7]
	// Results
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // target_index[3:0], step_amount[17:4],
	                                                  // jump_row[20:18], jump_column[24:21]
	output logic [1:0]                     m_tuser,   // event_kind[1:0]
	// Configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [csed_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [csed_pkg::CC_W-1:0]      cfg_data
);
	import csed_pkg::*;

	cfg_t    cfg_q;
	logic    q_full;
	logic    q_push;
	cmd_t    q_push_cmd;
	logic    q_pop;
	cmd_t    q_pop_cmd;
	logic    q_not_empty;
	result_t res;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.button_base_cc <= RST_BUTTON_BASE;
			cfg_q.speed_dial_cc  <= RST_SPEED_DIAL;
			cfg_q.knob_base_cc   <= RST_KNOB_BASE;
			cfg_q.step_divisor   <= RST_STEP_DIV;
			cfg_q.acceleration   <= RST_ACCEL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BUTTON_BASE: cfg_q.button_base_cc <= cfg_data;
				REG_SPEED_DIAL:  cfg_q.speed_dial_cc  <= cfg_data;
				REG_KNOB_BASE:   cfg_q.knob_base_cc   <= cfg_data;
				REG_STEP_DIV:    cfg_q.step_divisor   <= cfg_data;
				REG_ACCEL:       cfg_q.acceleration   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	csed_front #(
		.BUTTON_COUNT  (BUTTON_COUNT),
		.RELATIVE_KNOBS(RELATIVE_KNOBS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cc_number(s_tdata[6:0]),
		.cc_value (s_tdata[13:7]),
		.q_full   (q_full),
		.push     (q_push),
		.push_cmd (q_push_cmd)
	);

	csed_queue #(
		.DEPTH(4)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_pop_cmd),
		.not_empty(q_not_empty)
	);

	csed_back #(
		.RELATIVE_KNOBS(RELATIVE_KNOBS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_not_empty),
		.q_pop    (q_pop),
		.q_cmd    (q_pop_cmd),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	// Result packing
	assign m_tdata = {7'b0, res.col, res.row, res.step, res.target};
	assign m_tuser = res.kind;

endmodule
`default_nettype wire

// File: hw/rtl/csed_queue.sv
// Short command queue between the decode front and the execution back.
`default_nettype none
module csed_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  csed_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output csed_pkg::cmd_t pop_cmd,
	output logic           not_empty
);
	import csed_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/csed_front.sv
// Decode front: classifies events, tracks buttons and chords, scales knob deltas.
`default_nettype none
module csed_front #(
	parameter int BUTTON_COUNT   = 16,
	parameter int RELATIVE_KNOBS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  csed_pkg::cfg_t            cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [csed_pkg::CC_W-1:0] cc_number,
	input  logic [csed_pkg::CC_W-1:0] cc_value,
	input  logic                      q_full,
	output logic                      push,
	output csed_pkg::cmd_t            push_cmd
);
	import csed_pkg::*;

	localparam int HALF   = BUTTON_COUNT / 2;
	localparam int BIDX_W = $clog2(BUTTON_COUNT);
	localparam logic [BUTTON_COUNT-1:0] TOP_MASK =
		BUTTON_COUNT'((64'd1 << HALF) - 64'd1);
	localparam logic [BUTTON_COUNT-1:0] BOT_MASK = ~TOP_MASK;

	logic [BUTTON_COUNT-1:0] held_q;
	logic [BUTTON_COUNT-1:0] chord_q;

	logic                    accept;
	logic                    pressed;
	logic [CC_W:0]           diff_b;
	logic [CC_W:0]           diff_k;
	logic                    ge_b;
	logic                    in_btn;
	logic                    in_top;
	logic                    in_bot;
	logic                    in_knob;
	logic [BUTTON_COUNT-1:0] btn_bit;
	logic [BUTTON_COUNT-1:0] held_next;
	logic [BUTTON_COUNT-1:0] chord_mid;
	logic [BUTTON_COUNT-1:0] chord_next;
	logic                    chord_bottom;
	logic [COL_W-1:0]        col;
	logic signed [7:0]       d8;
	logic signed [7:0]       a8;
	logic signed [15:0]      prod;
	logic                    big_step;
	logic [STEP_W-1:0]       delta;
	logic                    has_result;
	cmd_t                    cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pressed  = (cc_value != '0);

	// Range tests against the configured controller numbers
	always_comb begin
		diff_b  = {1'b0, cc_number} - {1'b0, cfg.button_base_cc};
		diff_k  = {1'b0, cc_number} - {1'b0, cfg.knob_base_cc};
		ge_b    = (cc_number >= cfg.button_base_cc);
		in_btn  = ge_b && (diff_b < (CC_W+1)'(BUTTON_COUNT));
		in_top  = ge_b && (diff_b < (CC_W+1)'(HALF));
		in_bot  = ge_b && (diff_b >= (CC_W+1)'(HALF)) && (diff_b < (CC_W+1)'(2 * HALF));
		in_knob = (cc_number >= cfg.knob_base_cc) &&
			(diff_k < (CC_W+1)'(RELATIVE_KNOBS));
	end

	// Held mask and chord latch update
	always_comb begin
		btn_bit = '0;
		btn_bit[diff_b[BIDX_W-1:0]] = 1'b1;
		chord_mid = (in_btn && pressed && (held_q != '0)) ? held_q : chord_q;
		if (in_btn) begin
			held_next = pressed ? (held_q | btn_bit) : (held_q & ~btn_bit);
		end else begin
			held_next = held_q;
		end
		chord_next   = (held_next == '0) ? '0 : chord_mid;
		chord_bottom = |(chord_mid & BOT_MASK);
	end

	// Knob delta: 7-bit two's complement, accelerated above one step
	always_comb begin
		d8       = {cc_value[CC_W-1], cc_value};
		a8       = {1'b0, cfg.acceleration};
		prod     = d8 * a8;
		big_step = !((cc_value == 7'h00) || (cc_value == 7'h01) || (cc_value == 7'h7f));
		delta    = big_step ? prod[STEP_W-1:0] : {{(STEP_W-8){d8[7]}}, d8};
	end

	// Command build
	always_comb begin
		cmd        = '0;
		has_result = 1'b0;
		col        = in_top ? COL_W'(diff_b + 8'd1) : COL_W'(diff_b - 8'(HALF) + 8'd1);
		if (in_top || in_bot) begin
			cmd.target = col;
			if (!pressed && (chord_mid == '0)) begin
				has_result = 1'b1;
				cmd.kind   = in_top ? KIND_INC : KIND_DEC;
			end else if (pressed && (chord_mid != '0)) begin
				has_result = 1'b1;
				cmd.kind   = KIND_JUMP;
				cmd.col    = col;
				cmd.row    = (in_top ? 3'd1 : 3'd2) + (chord_bottom ? 3'd2 : 3'd0);
			end
		end else if (cc_number == cfg.speed_dial_cc) begin
			has_result  = 1'b1;
			cmd.is_knob = 1'b1;
			cmd.kind    = KIND_KNOB;
			cmd.slot    = '0;
			cmd.delta   = delta;
		end else if (in_knob) begin
			has_result  = 1'b1;
			cmd.is_knob = 1'b1;
			cmd.kind    = KIND_KNOB;
			cmd.slot    = SLOT_W'(diff_k + 8'd1);
			cmd.delta   = delta;
		end
	end

	assign push     = accept && has_result;
	assign push_cmd = cmd;

	// Button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			chord_q <= '0;
		end else if (accept) begin
			held_q  <= held_next;
			chord_q <= chord_next;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/csed_back.sv
// Execution back: knob remainders, serial divide by the scale, result register.
`default_nettype none
module csed_back #(
	parameter int RELATIVE_KNOBS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  csed_pkg::cfg_t    cfg,
	input  logic              q_valid,
	output logic              q_pop,
	input  csed_pkg::cmd_t    q_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output csed_pkg::result_t out_res
);
	import csed_pkg::*;

	localparam int KNOB_SLOTS = RELATIVE_KNOBS + 1;
	localparam int SIDX_W     = $clog2(KNOB_SLOTS);
	localparam int CNT_W      = $clog2(NUM_W);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_DIV,
		S_FIX
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [7:0]        rem_mem_q [KNOB_SLOTS];
	logic              neg_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [CC_W-1:0]   rem_q;
	logic [CC_W-1:0]   div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [SIDX_W-1:0] idx;
	logic [14:0]       sum_c;
	logic [14:0]       mag_c;
	logic [CC_W:0]     r_sh;
	logic              r_ge;
	logic [STEP_W-1:0] step_c;
	logic [7:0]        rem_fix;

	assign idx       = cmd_q.slot[SIDX_W-1:0];
	assign q_pop     = (state_q == S_IDLE) && q_valid && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Remainder plus delta, and its magnitude
	always_comb begin
		sum_c = {{7{rem_mem_q[idx][7]}}, rem_mem_q[idx]} + {cmd_q.delta[STEP_W-1], cmd_q.delta};
		mag_c = sum_c[14] ? (~sum_c + 15'd1) : sum_c;
	end

	// One restoring divide step
	always_comb begin
		r_sh = {rem_q, num_q[NUM_W-1]};
		r_ge = (r_sh >= {1'b0, div_q});
	end

	// Signed quotient with saturation, signed leftover
	always_comb begin
		if (!neg_q) begin
			step_c = (quo_q > STEP_POS_MAX) ? STEP_POS_MAX : quo_q;
		end else begin
			step_c = (quo_q > STEP_NEG_MAX) ? STEP_NEG_MAX : (~quo_q + 14'd1);
		end
		rem_fix = neg_q ? (~{1'b0, rem_q} + 8'd1) : {1'b0, rem_q};
	end

	// Sequencer, remainder store and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < KNOB_SLOTS; i++) begin
				rem_mem_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						cmd_q <= q_cmd;
						if (q_cmd.is_knob) begin
							state_q <= S_SUM;
						end else begin
							out_q.kind   <= q_cmd.kind;
							out_q.target <= q_cmd.target;
							out_q.step   <= '0;
							out_q.row    <= q_cmd.row;
							out_q.col    <= q_cmd.col;
							out_valid_q  <= 1'b1;
						end
					end
				end
				S_SUM: begin
					neg_q   <= sum_c[14];
					num_q   <= mag_c[NUM_W-1:0];
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= '0;
					div_q   <= (cfg.step_divisor == '0) ? CC_W'(1) : cfg.step_divisor;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= r_ge ? CC_W'(r_sh - {1'b0, div_q}) : r_sh[CC_W-1:0];
					num_q <= {num_q[NUM_W-2:0], 1'b0};
					quo_q <= {quo_q[NUM_W-2:0], r_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					rem_mem_q[idx] <= rem_fix;
					out_q.kind     <= KIND_KNOB;
					out_q.target   <= cmd_q.slot[TARGET_W-1:0];
					out_q.step     <= step_c;
					out_q.row      <= '0;
					out_q.col      <= '0;
					out_valid_q    <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/csed_checker.sv
// Port-level checker for the event decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module csed_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        cfg_ready
);
	import csed_pkg::*;

	// A stalled result holds its transaction
	`CSED_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Button results carry no step
	`CSED_ASSERT(a_btn_no_step, clk, arst_n, m_tvalid && (m_tuser != KIND_KNOB) |-> (m_tdata[17:4] == 14'd0))

	// Only jumps carry a row and a column
	`CSED_ASSERT(a_row_col_jump_only, clk, arst_n, m_tvalid && (m_tuser != KIND_JUMP) |-> (m_tdata[24:18] == 7'd0))

	// A jump names a row and targets its own column
	`CSED_ASSERT(a_jump_fields, clk, arst_n, m_tvalid && (m_tuser == KIND_JUMP) |-> (m_tdata[20:18] != 3'd0) && (m_tdata[24:21] == m_tdata[3:0]))

	// Configuration port never stalls
	`CSED_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready)

endmodule

bind control_surface_event_decoder csed_checker u_csed_checker (.*);
`default_nettype wire
